// File: rtl/waypoint_line_interpolator_top_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef WAYPOINT_LINE_INTERPOLATOR_TOP_DEFINES_SVH
`define WAYPOINT_LINE_INTERPOLATOR_TOP_DEFINES_SVH
`define WLI_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define WLI_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/wli_pkg.sv
// ----------------------------------------------------------------------------
// wli_pkg
// Constants shared by the waypoint line interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package wli_pkg;
  localparam int MAX_STEPS_DEF = 63;
  localparam int COORD_BITS_DEF = 24;
  localparam int STEP_BITS = 24;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd22610;
endpackage
`default_nettype wire

// File: rtl/wli_if.sv
// ----------------------------------------------------------------------------
// wli_wp_if / wli_pt_if
// Valid/ready channels for waypoint and point words.
// ----------------------------------------------------------------------------
`default_nettype none
interface wli_wp_if #(parameter int CB = 24);
  logic valid;
  logic ready;
  logic signed [CB-1:0] wp_x;
  logic signed [CB-1:0] wp_y;
  logic path_start;
  modport source (output valid, wp_x, wp_y, path_start, input ready);
  modport sink (input valid, wp_x, wp_y, path_start, output ready);
endinterface

interface wli_pt_if #(parameter int CB = 24);
  logic valid;
  logic ready;
  logic signed [CB-1:0] pt_x;
  logic signed [CB-1:0] pt_y;
  logic segment_last;
  logic steps_clamped;
  modport source (output valid, pt_x, pt_y, segment_last, steps_clamped, input ready);
  modport sink (input valid, pt_x, pt_y, segment_last, steps_clamped, output ready);
endinterface
`default_nettype wire

// File: rtl/waypoint_line_interpolator_top.sv
// ----------------------------------------------------------------------------
// waypoint_line_interpolator_top
// Splits each waypoint segment into evenly spaced points.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// in_       in   wp_x, wp_y, path_start
// out_      out  pt_x, pt_y, segment_last, steps_clamped
// cfg_      in   step_length write
// A path start word only sets the start point. A segment word forms dx^2+dy^2
// in S_SQX and S_SQY and then searches for n (at most MAX_STEPS) on the one
// shared multiplier. Each of the n+1 points then takes two divider runs, x and
// y (none when n is zero), before S_OUT passes it out.
// Reset is synchronous, active low. A stalled output holds its word while the
// next point is prepared, and the input is ready only when idle with no word out.
`default_nettype none
`include "waypoint_line_interpolator_top_defines.svh"
module waypoint_line_interpolator_top #(
  parameter int MAX_STEPS = wli_pkg::MAX_STEPS_DEF,
  parameter int COORD_BITS = wli_pkg::COORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  wli_wp_if.sink in_ch,
  wli_pt_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [wli_pkg::STEP_BITS-1:0] cfg_wdata
);
  localparam int SB = wli_pkg::STEP_BITS;
  localparam int NB = $clog2(MAX_STEPS + 1);
  localparam int DB = COORD_BITS + 1;
  localparam int PW = DB + NB + 2;
  localparam int RW = SB + NB;
  localparam int MW = (RW > DB) ? RW : DB;
  localparam int QW = 2 * DB;

  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQY, S_SEARCH, S_DIVX, S_DIVY, S_OUT
  } state_t;
  state_t state_r;
  logic [SB-1:0] step_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, ex_r, ey_r, cx_r, cy_r, ox_r, oy_r;
  logic signed [DB-1:0] dx_r, dy_r;
  logic have_r, clamp_r, last_r, ovalid_r, div_busy_r;
  logic [QW-1:0] sq_r;
  logic [RW-1:0] reach_r;
  logic [NB-1:0] n_r, j_r;
  logic div_start;
  logic div_done;
  logic [PW-1:0] num;
  logic [PW-1:0] quo;
  logic [PW-1:0] prod;
  logic signed [DB-1:0] dsel;
  logic [DB-1:0] dmag;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic signed [DB:0] sum;

  assign dsel = ((state_r == S_DIVX) || (state_r == S_SQX)) ? dx_r : dy_r;
  assign dmag = dsel[DB-1] ? DB'(-dsel) : DB'(dsel);

  always_comb begin
    case (state_r)
      S_SEARCH: begin
        mul_a = MW'(reach_r);
        mul_b = MW'(reach_r);
      end
      S_DIVX, S_DIVY: begin
        mul_a = MW'(dmag);
        mul_b = MW'(j_r);
      end
      default: begin
        mul_a = MW'(dmag);
        mul_b = MW'(dmag);
      end
    endcase
  end

  assign mul_p = (2*MW)'(mul_a) * (2*MW)'(mul_b);
  assign prod = PW'(mul_p);
  assign num = (prod << 1) + PW'(n_r);
  assign sum = (DB+1)'(dsel[DB-1] ? -$signed({1'b0, quo[DB-1:0]})
                                  : $signed({1'b0, quo[DB-1:0]}))
             + (DB+1)'((state_r == S_DIVX) ? px_r : py_r);

  wli_divider #(.NW(PW), .DW(NB + 1)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num),
    .den({n_r, 1'b0}), .done(div_done), .quo(quo)
  );

  assign div_start = ((state_r == S_DIVX) || (state_r == S_DIVY)) && !div_busy_r
                     && (n_r != '0);
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.pt_x = ox_r;
  assign out_ch.pt_y = oy_r;
  assign out_ch.segment_last = last_r;
  assign out_ch.steps_clamped = clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= wli_pkg::STEP_RESET;
      have_r <= 1'b0;
      ovalid_r <= 1'b0;
      div_busy_r <= 1'b0;
      last_r <= 1'b0;
      clamp_r <= 1'b0;
      n_r <= '0;
      j_r <= '0;
      px_r <= '0;
      py_r <= '0;
    end else begin
      if (cfg_we) step_r <= cfg_wdata;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            ex_r <= in_ch.wp_x;
            ey_r <= in_ch.wp_y;
            if (in_ch.path_start || !have_r) begin
              px_r <= in_ch.wp_x;
              py_r <= in_ch.wp_y;
              have_r <= 1'b1;
            end else begin
              dx_r <= DB'(in_ch.wp_x) - DB'(px_r);
              dy_r <= DB'(in_ch.wp_y) - DB'(py_r);
              state_r <= S_SQX;
            end
          end
        end
        S_SQX: begin
          sq_r <= QW'(mul_p);
          state_r <= S_SQY;
        end
        S_SQY: begin
          sq_r <= sq_r + QW'(mul_p);
          j_r <= '0;
          reach_r <= '0;
          state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          if (mul_p >= (2*MW)'(sq_r)) begin
            n_r <= j_r;
            clamp_r <= 1'b0;
            j_r <= '0;
            state_r <= S_DIVX;
          end else if (j_r == NB'(MAX_STEPS)) begin
            n_r <= NB'(MAX_STEPS);
            clamp_r <= 1'b1;
            j_r <= '0;
            state_r <= S_DIVX;
          end else begin
            j_r <= j_r + 1'b1;
            reach_r <= reach_r + RW'(step_r);
          end
        end
        S_DIVX: begin
          if (n_r == '0) begin
            cx_r <= px_r;
            cy_r <= py_r;
            state_r <= S_OUT;
          end else if (div_start) begin
            div_busy_r <= 1'b1;
          end else if (div_done) begin
            div_busy_r <= 1'b0;
            cx_r <= COORD_BITS'(sum);
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_start) begin
            div_busy_r <= 1'b1;
          end else if (div_done) begin
            div_busy_r <= 1'b0;
            cy_r <= COORD_BITS'(sum);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
            ox_r <= cx_r;
            oy_r <= cy_r;
            last_r <= (j_r == n_r);
            if (j_r == n_r) begin
              px_r <= ex_r;
              py_r <= ey_r;
              state_r <= S_IDLE;
            end else begin
              j_r <= j_r + 1'b1;
              state_r <= S_DIVX;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `WLI_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `WLI_ASSERT_NXT(a_out_hold, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r)
  `WLI_ASSERT_NXT(a_out_stable, clk, rst_n, ovalid_r && !out_ch.ready, $stable({ox_r, oy_r}))
  `WLI_ASSERT_IMP(a_j_le_n, clk, rst_n, state_r == S_OUT, j_r <= n_r)
endmodule
`default_nettype wire

// File: rtl/wli_divider.sv
// ----------------------------------------------------------------------------
// wli_divider
// Restoring divider for rounded quotients, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wli_divider #(
  parameter int NW = 32,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [NW-1:0] n_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic done_r;
  logic [DW:0] trial;

  assign trial = {rem_r, n_r[NW-1]};
  assign quo = q_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r <= num;
        d_r <= den;
        rem_r <= '0;
        q_r <= '0;
        cnt_r <= CW'(NW);
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (trial >= {1'b0, d_r}) begin
          rem_r <= DW'(trial - {1'b0, d_r});
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DW-1:0];
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
